>>> rtl/rau_pkg.sv
// Shared types and constants for the rational arithmetic unit.
// Used by rau_ctrl, rau_dp and rational_arith_unit; depends on nothing.
`timescale 1ns / 1ps

package rau_pkg;

    localparam int OperandWidth = 32;           // numerator bits taken from each operand
    localparam int NumW         = 32;
    localparam int DenW         = 31;
    localparam int KindW        = 3;
    localparam int ProdW        = 64;           // signed cross products and sums
    localparam int MagW         = 63;           // magnitudes, GCD and quotients
    localparam int ResDenW      = 62;
    localparam int ShiftW       = $clog2(MagW); // common power-of-two count
    localparam int DivSteps     = MagW;         // one quotient bit a cycle
    localparam int CntW         = $clog2(DivSteps);
    localparam int NumPad       = NumW - OperandWidth;

    localparam logic [DenW-1:0] DenMask =
        DenW'((64'd1 << (OperandWidth - 1)) - 64'd1);

    typedef enum logic [KindW-1:0] {
        KIND_ADD = 3'd0,
        KIND_SUB = 3'd1,
        KIND_MUL = 3'd2,
        KIND_DIV = 3'd3,
        KIND_EQ  = 3'd4
    } t_kind;

    typedef struct packed {
        logic [KindW-1:0]       kind;
        logic signed [NumW-1:0] a_num;
        logic [DenW-1:0]        a_den;
        logic signed [NumW-1:0] b_num;
        logic [DenW-1:0]        b_den;
    } t_req;

    typedef struct packed {
        logic signed [ProdW-1:0] res_num;
        logic [ResDenW-1:0]      res_den;
        logic                    is_equal;
        logic                    div_by_zero;
    } t_res;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic mul_a;
        logic mul_b;
        logic mul_c;
        logic sum;
        logic sign;
        logic gcd_step;
        logic scale;
        logic div_step;
        logic out_load;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic compute;
        logic gcd_done;
        logic div_last;
    } t_sts;

endpackage

>>> rtl/rau_dp.sv
// Datapath of the rational arithmetic unit: shared multiplier, sign handling,
// binary GCD, two-lane restoring divider and result register. Uses rau_pkg.
`timescale 1ns / 1ps

module rau_dp (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  rau_pkg::t_cmd i_cmd,
    input  rau_pkg::t_req i_req,
    output rau_pkg::t_sts o_sts,
    output rau_pkg::t_res o_res
);

    logic [rau_pkg::KindW-1:0]        r_kind;
    logic signed [rau_pkg::NumW-1:0]  r_an;
    logic signed [rau_pkg::NumW-1:0]  r_bn;
    logic [rau_pkg::DenW-1:0]         r_ad;
    logic [rau_pkg::DenW-1:0]         r_bd;
    logic signed [rau_pkg::ProdW-1:0] r_p1;
    logic signed [rau_pkg::ProdW-1:0] r_p2;
    logic signed [rau_pkg::ProdW-1:0] r_p3;
    logic                             r_neg;
    logic                             r_dz;
    logic [rau_pkg::MagW-1:0]         r_u;
    logic [rau_pkg::MagW-1:0]         r_v;
    logic [rau_pkg::ShiftW-1:0]       r_k;
    logic [rau_pkg::MagW-1:0]         r_g;
    logic [rau_pkg::MagW-1:0]         r_quo_n;
    logic [rau_pkg::MagW-1:0]         r_quo_d;
    logic [rau_pkg::MagW-1:0]         r_rem_n;
    logic [rau_pkg::MagW-1:0]         r_rem_d;
    logic [rau_pkg::CntW-1:0]         r_cnt;
    rau_pkg::t_res                    r_res;

    logic signed [rau_pkg::NumW-1:0]  w_an_sh;
    logic signed [rau_pkg::NumW-1:0]  w_bn_sh;
    logic signed [rau_pkg::NumW-1:0]  w_mul_x;
    logic signed [rau_pkg::NumW-1:0]  w_mul_y;
    logic signed [rau_pkg::ProdW-1:0] w_prod;
    logic                             w_compute;
    logic                             w_u_ge;
    logic [rau_pkg::MagW-1:0]         w_diff;
    logic [rau_pkg::MagW:0]           w_sh_n;
    logic [rau_pkg::MagW:0]           w_sh_d;
    logic                             w_fit_n;
    logic                             w_fit_d;
    logic [rau_pkg::ProdW-1:0]        w_qn;

    // keep the low OperandWidth bits of each numerator, sign-extended
    assign w_an_sh = i_req.a_num <<< rau_pkg::NumPad;
    assign w_bn_sh = i_req.b_num <<< rau_pkg::NumPad;

    assign w_compute = (r_kind == rau_pkg::KIND_ADD) || (r_kind == rau_pkg::KIND_SUB)
                    || (r_kind == rau_pkg::KIND_MUL) || (r_kind == rau_pkg::KIND_DIV);

    // one multiplier, three passes: an*bd (or an*bn), bn*ad, ad*bd (or ad*bn)
    always_comb begin
        if (i_cmd.mul_b) begin
            w_mul_x = r_bn;
            w_mul_y = $signed({1'b0, r_ad});
        end else if (i_cmd.mul_c) begin
            w_mul_x = $signed({1'b0, r_ad});
            w_mul_y = (r_kind == rau_pkg::KIND_DIV) ? r_bn : $signed({1'b0, r_bd});
        end else begin
            w_mul_x = r_an;
            w_mul_y = (r_kind == rau_pkg::KIND_MUL) ? r_bn : $signed({1'b0, r_bd});
        end
    end

    assign w_prod = rau_pkg::ProdW'(w_mul_x) * rau_pkg::ProdW'(w_mul_y);

    assign w_u_ge = (r_u >= r_v);
    assign w_diff = w_u_ge ? (r_u - r_v) : (r_v - r_u);

    assign w_sh_n  = {r_rem_n, r_quo_n[rau_pkg::MagW-1]};
    assign w_sh_d  = {r_rem_d, r_quo_d[rau_pkg::MagW-1]};
    assign w_fit_n = (w_sh_n >= {1'b0, r_g});
    assign w_fit_d = (w_sh_d >= {1'b0, r_g});

    assign w_qn = {1'b0, r_quo_n};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind <= i_req.kind;
            r_an   <= w_an_sh >>> rau_pkg::NumPad;
            r_bn   <= w_bn_sh >>> rau_pkg::NumPad;
            r_ad   <= i_req.a_den & rau_pkg::DenMask;
            r_bd   <= i_req.b_den & rau_pkg::DenMask;
        end

        if (i_cmd.mul_a) begin
            r_p1 <= w_prod;
        end
        if (i_cmd.mul_b) begin
            r_p2 <= w_prod;
        end
        if (i_cmd.mul_c) begin
            r_p3 <= w_prod;
        end

        if (i_cmd.sum) begin
            if (r_kind == rau_pkg::KIND_ADD) begin
                r_p1 <= r_p1 + r_p2;
            end else if (r_kind == rau_pkg::KIND_SUB) begin
                r_p1 <= r_p1 - r_p2;
            end
            // a zero denominator is forced to one and flagged
            r_dz <= (r_p3 == '0);
            if (r_p3 == '0) begin
                r_p3 <= rau_pkg::ProdW'(1);
            end
        end

        // split into sign and magnitudes; the quotient registers hold the dividends
        if (i_cmd.sign) begin
            r_neg   <= (r_p1[rau_pkg::ProdW-1] != r_p3[rau_pkg::ProdW-1]) && (r_p1 != '0);
            r_u     <= r_p1[rau_pkg::ProdW-1] ? rau_pkg::MagW'(-r_p1) : rau_pkg::MagW'(r_p1);
            r_v     <= r_p3[rau_pkg::ProdW-1] ? rau_pkg::MagW'(-r_p3) : rau_pkg::MagW'(r_p3);
            r_quo_n <= r_p1[rau_pkg::ProdW-1] ? rau_pkg::MagW'(-r_p1) : rau_pkg::MagW'(r_p1);
            r_quo_d <= r_p3[rau_pkg::ProdW-1] ? rau_pkg::MagW'(-r_p3) : rau_pkg::MagW'(r_p3);
            r_k     <= '0;
        end

        // binary GCD: v stays non-zero, the loop ends when u reaches zero
        if (i_cmd.gcd_step) begin
            if (!r_u[0] && !r_v[0]) begin
                r_u <= r_u >> 1;
                r_v <= r_v >> 1;
                r_k <= r_k + rau_pkg::ShiftW'(1);
            end else if (!r_u[0]) begin
                r_u <= r_u >> 1;
            end else if (!r_v[0]) begin
                r_v <= r_v >> 1;
            end else if (w_u_ge) begin
                r_u <= w_diff >> 1;
            end else begin
                r_v <= w_diff >> 1;
            end
        end

        if (i_cmd.scale) begin
            r_g     <= r_v << r_k;
            r_rem_n <= '0;
            r_rem_d <= '0;
            r_cnt   <= '0;
        end

        if (i_cmd.div_step) begin
            r_rem_n <= w_fit_n ? rau_pkg::MagW'(w_sh_n - {1'b0, r_g})
                               : w_sh_n[rau_pkg::MagW-1:0];
            r_rem_d <= w_fit_d ? rau_pkg::MagW'(w_sh_d - {1'b0, r_g})
                               : w_sh_d[rau_pkg::MagW-1:0];
            r_quo_n <= {r_quo_n[rau_pkg::MagW-2:0], w_fit_n};
            r_quo_d <= {r_quo_d[rau_pkg::MagW-2:0], w_fit_d};
            r_cnt   <= r_cnt + rau_pkg::CntW'(1);
        end

        if (i_cmd.out_load) begin
            if (w_compute) begin
                r_res.res_num <= r_neg ? $signed(rau_pkg::ProdW'(0) - w_qn) : $signed(w_qn);
                r_res.res_den <= r_quo_d[rau_pkg::ResDenW-1:0];
            end else begin
                r_res.res_num <= '0;
                r_res.res_den <= '0;
            end
            r_res.is_equal    <= (r_kind == rau_pkg::KIND_EQ) && (r_an == r_bn) && (r_ad == r_bd);
            r_res.div_by_zero <= w_compute && r_dz;
        end
    end

    assign o_sts.compute  = w_compute;
    assign o_sts.gcd_done = (r_u == '0);
    assign o_sts.div_last = (r_cnt == rau_pkg::CntW'(rau_pkg::DivSteps - 1));
    assign o_res          = r_res;

    a_gcd_v_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.gcd_step |-> (r_v != '0))
        else $error("gcd: second operand reached zero");

    a_rem_below_g: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_step |-> ((r_rem_n < r_g) && (r_rem_d < r_g)))
        else $error("divider: remainder not below divisor");

    a_exact_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.out_load && w_compute) |-> ((r_rem_n == '0) && (r_rem_d == '0)))
        else $error("divider: reduction by gcd left a remainder");

endmodule

>>> rtl/rau_ctrl.sv
// Sequencer of the rational arithmetic unit: steps the datapath through
// products, sum, sign split, GCD, scale, divide and result load. Uses rau_pkg.
`timescale 1ns / 1ps

module rau_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    output logic          o_req_ready,
    output logic          o_res_valid,
    input  logic          i_res_ready,
    output rau_pkg::t_cmd o_cmd,
    input  rau_pkg::t_sts i_sts
);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b00_0000_0001,
        S_MUL_A = 10'b00_0000_0010,
        S_MUL_B = 10'b00_0000_0100,
        S_MUL_C = 10'b00_0000_1000,
        S_SUM   = 10'b00_0001_0000,
        S_SIGN  = 10'b00_0010_0000,
        S_GCD   = 10'b00_0100_0000,
        S_SCALE = 10'b00_1000_0000,
        S_DIV   = 10'b01_0000_0000,
        S_OUT   = 10'b10_0000_0000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   w_out_free;

    assign w_out_free = !r_out_valid || i_res_ready;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_res_ready;
        o_cmd       = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_MUL_A;
                end
            end
            S_MUL_A: begin
                o_cmd.mul_a = 1'b1;
                n_state     = i_sts.compute ? S_MUL_B : S_OUT;
            end
            S_MUL_B: begin
                o_cmd.mul_b = 1'b1;
                n_state     = S_MUL_C;
            end
            S_MUL_C: begin
                o_cmd.mul_c = 1'b1;
                n_state     = S_SUM;
            end
            S_SUM: begin
                o_cmd.sum = 1'b1;
                n_state   = S_SIGN;
            end
            S_SIGN: begin
                o_cmd.sign = 1'b1;
                n_state    = S_GCD;
            end
            S_GCD: begin
                if (i_sts.gcd_done) begin
                    n_state = S_SCALE;
                end else begin
                    o_cmd.gcd_step = 1'b1;
                end
            end
            S_SCALE: begin
                o_cmd.scale = 1'b1;
                n_state     = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                // hold until the output register is free
                if (w_out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_req_ready = (r_state == S_IDLE);
    assign o_res_valid = r_out_valid;

    a_div_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && i_sts.div_last) |=> (r_state == S_OUT))
        else $error("ctrl: divide did not finish after its last step");

    a_out_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && w_out_free) |=> (r_out_valid && r_state == S_IDLE))
        else $error("ctrl: result not presented after load");

endmodule

>>> rtl/rational_arith_unit.sv
// Rational arithmetic unit: add, subtract, multiply, divide or compare two fractions,
// result reduced by the GCD. Arithmetic runs the three products, sum, sign split,
// binary GCD (one shift-subtract a cycle), scale and a two-lane restoring divide;
// compare and unused codes go from the first product straight to the result load.
// One request at a time; the next can be taken in the cycle after the result is loaded,
// while that result still waits in the output register. Reset (synchronous, active
// low) returns the sequencer to idle and empties the output register.
`timescale 1ns / 1ps

module rational_arith_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    output logic          o_req_ready,
    input  rau_pkg::t_req i_req,
    output logic          o_res_valid,
    input  logic          i_res_ready,
    output rau_pkg::t_res o_res
);

    rau_pkg::t_cmd w_cmd;
    rau_pkg::t_sts w_sts;

    rau_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .o_res_valid (o_res_valid),
        .i_res_ready (i_res_ready),
        .o_cmd       (w_cmd),
        .i_sts       (w_sts)
    );

    rau_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .i_req   (i_req),
        .o_sts   (w_sts),
        .o_res   (o_res)
    );

endmodule
